// File: design/tlpc_pkg.sv
package tlpc_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // Field widths
    localparam int COORD_W = 16;
    localparam int NUM_W   = 6;
    localparam int LEN_W   = 24;
    localparam int STAT_W  = 2;

    // Square root datapath: 34-bit radicand, 17 root bits, one per cycle
    localparam int RAD_W  = 34;
    localparam int ROOT_W = 17;
    localparam int REM_W  = 20;
    localparam int CNT_W  = 5;

    // Number of city flags in the visited map
    localparam int MAP_DEPTH = 64;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Tour status codes
    localparam logic [STAT_W-1:0] ST_VALID    = 2'd0;
    localparam logic [STAT_W-1:0] ST_HOME_BAD = 2'd1;
    localparam logic [STAT_W-1:0] ST_PERM_BAD = 2'd2;

    // Result of the shared square root unit
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQX  = 5'b00010,
        S_SQY  = 5'b00100,
        S_ROOT = 5'b01000,
        S_DONE = 5'b10000
    } tlpc_state_t;

endpackage

// File: design/tour_length_and_permutation_check_top.sv
// Closed tour length and permutation check.
// Input stream: one city per request, in visiting order. s_axis_tdata carries
// x and y (signed Q1.14) and the city number; s_axis_tlast marks the last city.
// Output stream: one request per tour, sent after the last city: the closed
// tour length (unsigned Q10.14, saturating) and a status (valid, first city
// not zero, or missing/repeated/out-of-range city).
// Each leg is floor(sqrt(dx^2 + dy^2)), computed by one shared squarer and a
// bit-serial square root unit producing one root bit per cycle (17 bits).
// Steps: the first city of a tour is only accepted; a later city is accepted,
// then the x and y differences are squared in turn, the square root is taken
// bit by bit and the leg is accumulated. The last city also adds the closing
// leg and then posts the result; a single-city tour goes straight to posting.
// s_axis_tready is low while a city is in progress.
// The result sits in an output register; a stalled receiver stalls the block
// only when a further tour ends before the previous result has been taken.
// Reset clears the visited map, counters and running length; the same
// clearing happens as each result is posted.
module tour_length_and_permutation_check_top #(
    parameter int MAX_CITIES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] coord_x, [31:16] coord_y, [37:32] city_number, [39:38] zero
    input  logic [tlpc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [23:0] tour_length, [25:24] tour_status, [31:26] zero
    output logic [tlpc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import tlpc_pkg::*;

    localparam int CW = $clog2(MAX_CITIES + 2);
    localparam int XW = (CW > 7) ? CW : 7;

    tlpc_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_W-1:0] oth_x_reg, oth_y_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [2*COORD_W:0]        sqx_reg;

    logic                 last_reg;
    logic                 closing_reg;
    logic                 home_bad_reg;
    logic                 repeat_reg;
    logic [NUM_W-1:0]     max_num_reg;
    logic [MAP_DEPTH-1:0] visited_reg;
    logic [CW-1:0]        count_reg;
    logic [LEN_W-1:0]     length_reg;

    logic                 out_valid_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [STAT_W-1:0]    out_status_reg;

    logic signed [COORD_W-1:0] in_x, in_y;
    logic [NUM_W-1:0]          in_num;
    logic                      accept;
    logic                      out_load;

    logic signed [COORD_W-1:0] sq_a, sq_b;
    logic signed [COORD_W:0]   diff;
    logic signed [2*COORD_W+1:0] sq;
    logic [RAD_W-1:0]          radicand;
    logic                      sqrt_start;
    sqrt_res_t                 sqrt_res;

    logic [LEN_W:0]            len_sum;
    logic [LEN_W-1:0]          len_sat;
    logic [STAT_W-1:0]         status;

    // Input fields
    assign in_x   = $signed(s_axis_tdata[15:0]);
    assign in_y   = $signed(s_axis_tdata[31:16]);
    assign in_num = s_axis_tdata[37:32];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // Shared squarer: x difference in S_SQX, y difference in S_SQY
    assign sq_a = (state_reg == S_SQY) ? cur_y_reg : cur_x_reg;
    assign sq_b = (state_reg == S_SQY) ? oth_y_reg : oth_x_reg;
    assign diff = $signed({sq_a[COORD_W-1], sq_a}) - $signed({sq_b[COORD_W-1], sq_b});
    assign sq   = diff * diff;

    assign radicand   = RAD_W'(sqx_reg) + RAD_W'(sq[2*COORD_W:0]);
    assign sqrt_start = (state_reg == S_SQY);

    tlpc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .res      (sqrt_res)
    );

    // Saturating accumulate of the leg length
    assign len_sum = {1'b0, length_reg} + (LEN_W+1)'(sqrt_res.root);
    assign len_sat = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];

    // Final status; with no repeats, all of 0..n-1 are present iff max < n
    always_comb
    begin
        if (home_bad_reg)
            status = ST_HOME_BAD;
        else if (repeat_reg || (count_reg > CW'(MAX_CITIES)) ||
                 (XW'(count_reg) > XW'(MAP_DEPTH)))
            status = ST_PERM_BAD;
        else if (XW'(max_num_reg) >= XW'(count_reg))
            status = ST_PERM_BAD;
        else
            status = ST_VALID;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg != '0)
                        state_next = S_SQX;
                    else if (s_axis_tlast)
                        state_next = S_DONE;
                end
            end
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_ROOT;
            S_ROOT:
            begin
                if (sqrt_res.done)
                begin
                    if (last_reg && !closing_reg)
                        state_next = S_SQX;
                    else if (last_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and tour state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            home_bad_reg  <= 1'b0;
            repeat_reg    <= 1'b0;
            max_num_reg   <= '0;
            visited_reg   <= '0;
            count_reg     <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                last_reg    <= s_axis_tlast;
                closing_reg <= (count_reg == '0);
                if (count_reg == '0)
                    home_bad_reg <= (in_num != '0);
                if (visited_reg[in_num])
                    repeat_reg <= 1'b1;
                visited_reg[in_num] <= 1'b1;
                if (in_num > max_num_reg)
                    max_num_reg <= in_num;
                if (count_reg <= CW'(MAX_CITIES))
                    count_reg <= count_reg + 1'b1;
            end

            if ((state_reg == S_ROOT) && sqrt_res.done)
            begin
                length_reg <= len_sat;
                if (last_reg)
                    closing_reg <= 1'b1;
            end

            // Post the result and return to the reset state
            if (out_load)
            begin
                last_reg     <= 1'b0;
                closing_reg  <= 1'b0;
                home_bad_reg <= 1'b0;
                repeat_reg   <= 1'b0;
                max_num_reg  <= '0;
                visited_reg  <= '0;
                count_reg    <= '0;
                length_reg   <= '0;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Coordinates and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg  <= in_x;
            cur_y_reg  <= in_y;
            prev_x_reg <= in_x;
            prev_y_reg <= in_y;
            oth_x_reg  <= prev_x_reg;
            oth_y_reg  <= prev_y_reg;
            if (count_reg == '0)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
        end
        // Second leg of the last city goes back to the first city
        if ((state_reg == S_ROOT) && sqrt_res.done && last_reg && !closing_reg)
        begin
            oth_x_reg <= first_x_reg;
            oth_y_reg <= first_y_reg;
        end
        if (state_reg == S_SQX)
            sqx_reg <= sq[2*COORD_W:0];
        if (out_load)
        begin
            out_len_reg    <= length_reg;
            out_status_reg <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_status_reg, out_len_reg});

`ifndef SYNTHESIS
    a_root_only_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_res.done |-> (state_reg == S_ROOT))
        else $error("square root finished outside root state");

    a_done_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> last_reg)
        else $error("result posted without a last city");

    a_clear_after_post: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((visited_reg == '0) && (count_reg == '0) && (length_reg == '0)))
        else $error("tour state not cleared after result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CITIES + 1))
        else $error("city count beyond saturation");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_status_reg != 2'd3))
        else $error("undefined tour status");
`endif

endmodule

// File: design/tlpc_isqrt.sv
module tlpc_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tlpc_pkg::RAD_W-1:0] radicand,
    output tlpc_pkg::sqrt_res_t        res
);
    import tlpc_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    // One root digit: bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule
